>>> design/stok_pkg.sv
`default_nettype none

package stok_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;
	localparam logic [15:0] KW_BYTES = 16'd5;
	localparam int KW_COUNT = 7;

	localparam logic [4:0] K_EOF      = 5'd0;
	localparam logic [4:0] K_IDENT    = 5'd1;
	localparam logic [4:0] K_NUMBER   = 5'd2;
	localparam logic [4:0] K_STRING   = 5'd3;
	localparam logic [4:0] K_KW_FIRST = 5'd4;
	localparam logic [4:0] K_PLUS     = 5'd11;
	localparam logic [4:0] K_MINUS    = 5'd12;
	localparam logic [4:0] K_STAR     = 5'd13;
	localparam logic [4:0] K_SLASH    = 5'd14;
	localparam logic [4:0] K_LPAREN   = 5'd15;
	localparam logic [4:0] K_RPAREN   = 5'd16;
	localparam logic [4:0] K_ASSIGN   = 5'd17;
	localparam logic [4:0] K_EQ       = 5'd18;
	localparam logic [4:0] K_NEQ      = 5'd19;
	localparam logic [4:0] K_SEMI     = 5'd20;
	localparam logic [4:0] K_LBRACE   = 5'd21;
	localparam logic [4:0] K_RBRACE   = 5'd22;
	localparam logic [4:0] K_AND      = 5'd23;
	localparam logic [4:0] K_OR       = 5'd24;
	localparam logic [4:0] K_ERROR    = 5'd25;

	localparam logic [1:0] E_NONE       = 2'd0;
	localparam logic [1:0] E_UNEXPECTED = 2'd1;
	localparam logic [1:0] E_STR_NL     = 2'd2;
	localparam logic [1:0] E_STR_END    = 2'd3;

	// print true false if else while break
	localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
		40'h7072696e74, 40'h0074727565, 40'h66616c7365, 40'h0000006966,
		40'h00656c7365, 40'h7768696c65, 40'h627265616b
	};
	localparam logic [15:0] KW_LEN [KW_COUNT] = '{
		16'd5, 16'd4, 16'd5, 16'd2, 16'd4, 16'd5, 16'd5
	};

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_IDENT  = 4'd1,
		M_NUMBER = 4'd2,
		M_STRING = 4'd3,
		M_EQ     = 4'd4,
		M_BANG   = 4'd5,
		M_AMP    = 4'd6,
		M_BAR    = 4'd7,
		M_ERROR  = 4'd8
	} lex_mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [1:0]  err_code;
		logic [15:0] start_pos;
		logic [15:0] lex_len;
		logic [30:0] num_value;
		logic        last_of_run;
	} tok_t;

	function automatic tok_t mk_tok(input logic [4:0] k, input logic [1:0] e,
			input logic [15:0] s, input logic [15:0] l, input logic [30:0] n);
		tok_t t;
		t.kind = k;
		t.err_code = e;
		t.start_pos = s;
		t.lex_len = l;
		t.num_value = n;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	function automatic logic [4:0] ident_kind(input logic [15:0] len, input logic [39:0] kb);
		logic [4:0] k;
		k = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (len == KW_LEN[i] && kb == KW_TEXT[i])
				k = K_KW_FIRST + 5'(i);
		end
		return k;
	endfunction

endpackage

`default_nettype wire

>>> design/stok_lexer.sv
`default_nettype none

module stok_lexer #(
	parameter int POS_WIDTH = stok_pkg::POS_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     ch,
	input  wire logic           at_end,
	output stok_pkg::tok_t      res0,
	output stok_pkg::tok_t      res1,
	output logic [1:0]          res_cnt
);

	localparam logic [7:0] C_NL = 8'h0A;
	localparam logic [POS_WIDTH-1:0] POS_ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};

	stok_pkg::lex_mode_t mode_q, mode_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d, start_q, start_d, pos_nx;
	logic [15:0] len_q, len_d, len_nx;
	logic [30:0] num_q, num_d;
	logic [39:0] kbuf_q, kbuf_d;

	stok_pkg::tok_t a, b;
	logic a_v, b_v, consumed;
	logic is_space, is_alpha, is_digit;
	logic [3:0] dig;
	logic [34:0] num_prod;
	logic [7:0] want;
	logic [4:0] pair_kind;

	function automatic logic [15:0] lo16(input logic [POS_WIDTH-1:0] v);
		logic [POS_WIDTH+15:0] e;
		e = {16'b0, v};
		return e[15:0];
	endfunction

	assign is_space = (ch == " ") || (ch >= 8'd9 && ch <= 8'd13);
	assign is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
	assign is_digit = (ch >= "0" && ch <= "9");
	assign dig = ch[3:0];
	assign num_prod = {1'b0, num_q, 3'b0} + {3'b0, num_q, 1'b0} + {31'b0, dig};
	assign pos_nx = (&pos_q) ? pos_q : pos_q + POS_ONE;
	assign len_nx = (len_q == stok_pkg::LEN_MAX) ? len_q : len_q + 16'd1;

	always_comb begin
		want = "|";
		pair_kind = stok_pkg::K_OR;
		if (mode_q == stok_pkg::M_BANG) begin
			want = "=";
			pair_kind = stok_pkg::K_NEQ;
		end else if (mode_q == stok_pkg::M_AMP) begin
			want = "&";
			pair_kind = stok_pkg::K_AND;
		end
	end

	always_comb begin
		mode_d = mode_q;
		pos_d = pos_q;
		start_d = start_q;
		len_d = len_q;
		num_d = num_q;
		kbuf_d = kbuf_q;
		a = '0;
		b = '0;
		a_v = 1'b0;
		b_v = 1'b0;
		consumed = 1'b0;
		if (at_end) begin
			a_v = 1'b1;
			unique case (mode_q)
				stok_pkg::M_IDENT: a = stok_pkg::mk_tok(
					stok_pkg::ident_kind(len_q, kbuf_q), stok_pkg::E_NONE,
					lo16(start_q), len_q, 31'd0);
				stok_pkg::M_NUMBER: a = stok_pkg::mk_tok(stok_pkg::K_NUMBER,
					stok_pkg::E_NONE, lo16(start_q), len_q, num_q);
				stok_pkg::M_STRING: a = stok_pkg::mk_tok(stok_pkg::K_ERROR,
					stok_pkg::E_STR_END, lo16(start_q), len_q, 31'd0);
				stok_pkg::M_EQ: a = stok_pkg::mk_tok(stok_pkg::K_ASSIGN,
					stok_pkg::E_NONE, lo16(start_q), 16'd1, 31'd0);
				stok_pkg::M_BANG, stok_pkg::M_AMP, stok_pkg::M_BAR:
					a = stok_pkg::mk_tok(stok_pkg::K_ERROR, stok_pkg::E_UNEXPECTED,
						lo16(start_q), 16'd1, 31'd0);
				default: a_v = 1'b0;
			endcase
			b_v = 1'b1;
			b = stok_pkg::mk_tok(stok_pkg::K_EOF, stok_pkg::E_NONE, lo16(pos_q),
				16'd0, 31'd0);
			mode_d = stok_pkg::M_IDLE;
			pos_d = '0;
			start_d = '0;
			len_d = '0;
			num_d = '0;
			kbuf_d = '0;
		end else begin
			unique case (mode_q)
				stok_pkg::M_IDLE: consumed = 1'b0;
				stok_pkg::M_IDENT: begin
					if (is_alpha || is_digit) begin
						if (len_q < stok_pkg::KW_BYTES)
							kbuf_d = {kbuf_q[31:0], ch};
						len_d = len_nx;
						consumed = 1'b1;
					end else begin
						a_v = 1'b1;
						a = stok_pkg::mk_tok(stok_pkg::ident_kind(len_q, kbuf_q),
							stok_pkg::E_NONE, lo16(start_q), len_q, 31'd0);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_NUMBER: begin
					if (is_digit) begin
						num_d = (num_prod > {4'b0, stok_pkg::NUM_MAX}) ?
							stok_pkg::NUM_MAX : num_prod[30:0];
						len_d = len_nx;
						consumed = 1'b1;
					end else begin
						a_v = 1'b1;
						a = stok_pkg::mk_tok(stok_pkg::K_NUMBER, stok_pkg::E_NONE,
							lo16(start_q), len_q, num_q);
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_STRING: begin
					consumed = 1'b1;
					if (ch == "\"") begin
						a_v = 1'b1;
						a = stok_pkg::mk_tok(stok_pkg::K_STRING, stok_pkg::E_NONE,
							lo16(start_q), len_q, 31'd0);
						mode_d = stok_pkg::M_IDLE;
					end else if (ch == C_NL) begin
						a_v = 1'b1;
						a = stok_pkg::mk_tok(stok_pkg::K_ERROR, stok_pkg::E_STR_NL,
							lo16(start_q), len_q, 31'd0);
						mode_d = stok_pkg::M_ERROR;
					end else begin
						len_d = len_nx;
					end
				end
				stok_pkg::M_EQ: begin
					mode_d = stok_pkg::M_IDLE;
					a_v = 1'b1;
					if (ch == "=") begin
						a = stok_pkg::mk_tok(stok_pkg::K_EQ, stok_pkg::E_NONE,
							lo16(start_q), 16'd2, 31'd0);
						consumed = 1'b1;
					end else begin
						a = stok_pkg::mk_tok(stok_pkg::K_ASSIGN, stok_pkg::E_NONE,
							lo16(start_q), 16'd1, 31'd0);
					end
				end
				stok_pkg::M_BANG, stok_pkg::M_AMP, stok_pkg::M_BAR: begin
					consumed = 1'b1;
					a_v = 1'b1;
					if (ch == want) begin
						a = stok_pkg::mk_tok(pair_kind, stok_pkg::E_NONE,
							lo16(start_q), 16'd2, 31'd0);
						mode_d = stok_pkg::M_IDLE;
					end else begin
						a = stok_pkg::mk_tok(stok_pkg::K_ERROR, stok_pkg::E_UNEXPECTED,
							lo16(start_q), 16'd1, 31'd0);
						mode_d = stok_pkg::M_ERROR;
					end
				end
				default: begin
					mode_d = stok_pkg::M_ERROR;
					consumed = 1'b1;
				end
			endcase

			// non-space byte not taken by the pending token starts a new one
			if (!consumed && !is_space) begin
				if (is_alpha) begin
					mode_d = stok_pkg::M_IDENT;
					start_d = pos_q;
					len_d = 16'd1;
					kbuf_d = {32'b0, ch};
				end else if (is_digit) begin
					mode_d = stok_pkg::M_NUMBER;
					start_d = pos_q;
					len_d = 16'd1;
					num_d = {27'b0, dig};
				end else begin
					start_d = pos_q;
					b = stok_pkg::mk_tok(stok_pkg::K_ERROR, stok_pkg::E_NONE,
						lo16(pos_q), 16'd1, 31'd0);
					b_v = 1'b1;
					case (ch)
						"+": b.kind = stok_pkg::K_PLUS;
						"-": b.kind = stok_pkg::K_MINUS;
						"*": b.kind = stok_pkg::K_STAR;
						"/": b.kind = stok_pkg::K_SLASH;
						"(": b.kind = stok_pkg::K_LPAREN;
						")": b.kind = stok_pkg::K_RPAREN;
						";": b.kind = stok_pkg::K_SEMI;
						"{": b.kind = stok_pkg::K_LBRACE;
						"}": b.kind = stok_pkg::K_RBRACE;
						"=": begin
							mode_d = stok_pkg::M_EQ;
							b_v = 1'b0;
						end
						"!": begin
							mode_d = stok_pkg::M_BANG;
							b_v = 1'b0;
						end
						"&": begin
							mode_d = stok_pkg::M_AMP;
							b_v = 1'b0;
						end
						"|": begin
							mode_d = stok_pkg::M_BAR;
							b_v = 1'b0;
						end
						"\"": begin
							mode_d = stok_pkg::M_STRING;
							start_d = pos_nx;
							len_d = 16'd0;
							b_v = 1'b0;
						end
						default: begin
							b.err_code = stok_pkg::E_UNEXPECTED;
							mode_d = stok_pkg::M_ERROR;
						end
					endcase
				end
			end
			pos_d = pos_nx;
		end
	end

	always_comb begin
		res0 = a_v ? a : b;
		res1 = b;
		res_cnt = {1'b0, a_v} + {1'b0, b_v};
		if (a_v && b_v)
			res1.last_of_run = 1'b1;
		else
			res0.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stok_pkg::M_IDLE;
			pos_q <= '0;
			start_q <= '0;
			len_q <= '0;
			num_q <= '0;
			kbuf_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			start_q <= start_d;
			len_q <= len_d;
			num_q <= num_d;
			kbuf_q <= kbuf_d;
		end
	end

endmodule

`default_nettype wire

>>> design/stok_outq.sv
`default_nettype none

module stok_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     push_cnt,
	input  wire stok_pkg::tok_t d0,
	input  wire stok_pkg::tok_t d1,
	input  wire logic           pop,
	output stok_pkg::tok_t      head,
	output logic                not_empty,
	output logic                room
);

	localparam logic [stok_pkg::Q_AW:0] ROOM_MAX = (stok_pkg::Q_AW + 1)'(stok_pkg::Q_DEPTH - 2);

	stok_pkg::tok_t mem [stok_pkg::Q_DEPTH];
	logic [stok_pkg::Q_AW-1:0] wr_q, rd_q;
	logic [stok_pkg::Q_AW:0] cnt_q;

	assign head = mem[rd_q];
	assign not_empty = (cnt_q != '0);
	assign room = (cnt_q <= ROOM_MAX);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem[wr_q] <= d0;
		if (push_cnt == 2'd2)
			mem[wr_q + 1'b1] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + stok_pkg::Q_AW'(push_cnt);
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (stok_pkg::Q_AW + 1)'(push_cnt) - (stok_pkg::Q_AW + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

>>> design/source_tokenizer.sv
// Tokens of a byte are written into the result queue when the beat is taken and are
// shown from its head. One input byte per cycle while the queue has room; a byte
// that yields two tokens leaves one token at a time, from the single-read result
// queue of four entries. Input is taken whenever the queue has room for two tokens.
// Reset (arst_n low) returns the lexer to idle at position zero and empties the queue.
`default_nettype none

module source_tokenizer #(
	parameter int POS_WIDTH = stok_pkg::POS_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	input  wire logic        at_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       kind,
	output logic [1:0]       err_code,
	output logic [15:0]      start_pos,
	output logic [15:0]      lex_len,
	output logic [30:0]      num_value,
	output logic             last_of_run
);

	stok_pkg::tok_t res0, res1, head;
	logic [1:0] res_cnt, push_cnt;
	logic step, room;

	assign in_ready = room;
	assign step = in_valid && room;
	assign push_cnt = step ? res_cnt : 2'd0;

	stok_lexer #(.POS_WIDTH(POS_WIDTH)) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.ch      (ch),
		.at_end  (at_end),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	stok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.d0        (res0),
		.d1        (res1),
		.pop       (out_valid && out_ready),
		.head      (head),
		.not_empty (out_valid),
		.room      (room)
	);

	assign kind = head.kind;
	assign err_code = head.err_code;
	assign start_pos = head.start_pos;
	assign lex_len = head.lex_len;
	assign num_value = head.num_value;
	assign last_of_run = head.last_of_run;

endmodule

`default_nettype wire
